// ----- rtl/vgb_pkg.sv -----
// Shared constants, codes and the block request type of the video block generator.
`default_nettype none

package vgb_pkg;

    // Frame geometry in pixels and lines
    localparam int BORDER_TOP    = 68;
    localparam int BORDER_BOTTOM = 52;
    localparam int BORDER_LEFT   = 96;
    localparam int BORDER_RIGHT  = 160;
    localparam int SCREEN_WIDTH  = 512;
    localparam int SCREEN_HEIGHT = 192;
    localparam int TOTAL_W       = BORDER_LEFT + SCREEN_WIDTH + BORDER_RIGHT;
    localparam int TOTAL_H       = BORDER_TOP + SCREEN_HEIGHT + BORDER_BOTTOM;
    localparam int BLOCK_PIXELS  = 16;

    // Video memory layout
    localparam int VRAM_AW       = 15;
    localparam int ATTR_BASE     = 32 * 192;
    localparam int ATTR_OFFSET   = 'h2000;
    localparam logic [7:0] BORDER_ATTR = 8'hff;

    // Stream field widths
    localparam int IN_TDATA_W    = 48;
    localparam int OUT_TDATA_W   = 40;

    // Request codes carried on s_tuser
    localparam logic [1:0] FUNC_TICK = 2'd0;
    localparam logic [1:0] FUNC_VRAM = 2'd1;
    localparam logic [1:0] FUNC_PAL  = 2'd2;

    // Operation travelling from the fetch stage to the pixel stage
    typedef enum logic
    {
        OP_TICK,
        OP_PAL
    } op_t;

    // How the pixels of one block are formed
    typedef enum logic [2:0]
    {
        BLK_BLANK,
        BLK_BORDER,
        BLK_CELL,
        BLK_MODE3,
        BLK_MODE4
    } blk_kind_t;

    // One block request, or one palette write, for the pixel stage
    typedef struct packed
    {
        op_t             op;
        logic [3:0]      pal_addr;
        logic [6:0]      pal_data;
        blk_kind_t       kind;
        logic [3:0]      border_idx;
        logic [3:0][7:0] vbytes;
        logic [9:0]      beam_x;
        logic [8:0]      beam_y;
        logic [7:0]      attr;
        logic            irq;
    } desc_t;

endpackage

`default_nettype wire

// ----- rtl/vgb_ram.sv -----
// Single-port synchronous RAM with registered read data.
`default_nettype none

module vgb_ram #(
    parameter int ADDR_W = 15,
    parameter int DATA_W = 8
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [DATA_W-1:0] wdata,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    // Write on request, read the addressed entry every cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/vgb_fetch.sv -----
// Fetch stage: beam position, attribute latch, memory clear and reads for each block.
`default_nettype none

module vgb_fetch (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [vgb_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  wire logic [1:0]                        s_tuser,
    output logic                                   ram_we,
    output logic [vgb_pkg::VRAM_AW-1:0]            ram_addr,
    output logic [7:0]                             ram_wdata,
    input  wire logic [7:0]                        ram_rdata,
    output logic                                   desc_valid,
    input  wire logic                              desc_ready,
    output vgb_pkg::desc_t                         desc
);

    typedef enum logic [2:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_WAIT,
        ST_FINISH
    } state_t;

    state_t                         state_reg, state_next;
    logic [vgb_pkg::VRAM_AW-1:0]    clr_addr_reg, clr_addr_next;
    logic [9:0]                     beam_x_reg, beam_x_next;
    logic [8:0]                     beam_y_reg, beam_y_next;
    logic [7:0]                     attr_reg, attr_next;
    logic [1:0]                     rd_idx_reg, rd_idx_next;
    logic [1:0]                     rd_last_reg, rd_last_next;
    logic                           cap_valid_reg, cap_valid_next;
    logic [1:0]                     cap_idx_reg, cap_idx_next;
    logic [vgb_pkg::VRAM_AW-1:0]    addr0_reg, addr0_next;
    logic [vgb_pkg::VRAM_AW-1:0]    addr1_reg, addr1_next;
    vgb_pkg::desc_t                 desc_reg, desc_next;
    logic                           desc_valid_reg, desc_valid_next;

    // Request fields
    logic [1:0]                     func;
    logic [14:0]                    address;
    logic [7:0]                     data;
    logic [1:0]                     video_mode;
    logic [7:0]                     border_reg;
    logic [7:0]                     line_int;

    // Block decode at the current beam position
    logic                           accept;
    logic                           blank;
    logic                           in_border;
    logic                           irq;
    logic [7:0]                     sy;
    logic [8:0]                     sx;
    logic [4:0]                     cellx;
    logic [10:0]                    bx_inc;
    logic [vgb_pkg::VRAM_AW-1:0]    m1_bits_addr;
    logic [vgb_pkg::VRAM_AW-1:0]    m1_attr_addr;
    logic [vgb_pkg::VRAM_AW-1:0]    m2_cell_addr;
    logic [vgb_pkg::VRAM_AW-1:0]    m2_attr_addr;
    logic [vgb_pkg::VRAM_AW-1:0]    base_addr;
    logic [vgb_pkg::VRAM_AW-1:0]    rd_addr;

    assign address    = s_tdata[14:0];
    assign data       = s_tdata[22:15];
    assign video_mode = s_tdata[24:23];
    assign border_reg = s_tdata[32:25];
    assign line_int   = s_tdata[40:33];
    assign func       = s_tuser;

    // Take a request when idle and the block request slot is free or draining
    assign s_tready = (state_reg == ST_IDLE) && (!desc_valid_reg || desc_ready);
    assign accept   = s_tvalid && s_tready;

    // Classify the block
    assign blank     = video_mode[1] && border_reg[7];
    assign in_border = (beam_y_reg < 9'(vgb_pkg::BORDER_TOP))
                    || (beam_y_reg >= 9'(vgb_pkg::BORDER_TOP + vgb_pkg::SCREEN_HEIGHT))
                    || (beam_x_reg < 10'(vgb_pkg::BORDER_LEFT))
                    || (beam_x_reg >= 10'(vgb_pkg::BORDER_LEFT + vgb_pkg::SCREEN_WIDTH));
    assign irq = (line_int < 8'(vgb_pkg::SCREEN_HEIGHT))
              && (beam_x_reg == 10'(vgb_pkg::BORDER_LEFT + vgb_pkg::SCREEN_WIDTH))
              && (({1'b0, beam_y_reg} + 10'd1)
                  == ({2'b00, line_int} + 10'(vgb_pkg::BORDER_TOP)));

    // Screen coordinates and memory addresses
    assign sy    = 8'(beam_y_reg - 9'(vgb_pkg::BORDER_TOP));
    assign sx    = 9'(beam_x_reg - 10'(vgb_pkg::BORDER_LEFT));
    assign cellx = sx[8:4];
    assign m1_bits_addr = {2'b00, sy[7:6], sy[2:0], sy[5:3], cellx};
    assign m1_attr_addr = 15'(vgb_pkg::ATTR_BASE) + {5'b00000, sy[7:3], cellx};
    assign m2_cell_addr = {2'b00, sy, cellx};
    assign m2_attr_addr = m2_cell_addr + 15'(vgb_pkg::ATTR_OFFSET);
    assign base_addr    = {sy, sx[8:2]};
    assign bx_inc       = {1'b0, beam_x_reg} + 11'(vgb_pkg::BLOCK_PIXELS);

    // Select the read address of the current step
    assign rd_addr = (desc_reg.kind == vgb_pkg::BLK_CELL)
                   ? (rd_idx_reg[0] ? addr1_reg : addr0_reg)
                   : addr0_reg + {13'd0, rd_idx_reg};

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        beam_x_next     = beam_x_reg;
        beam_y_next     = beam_y_reg;
        attr_next       = attr_reg;
        rd_idx_next     = rd_idx_reg;
        rd_last_next    = rd_last_reg;
        cap_valid_next  = 1'b0;
        cap_idx_next    = cap_idx_reg;
        addr0_next      = addr0_reg;
        addr1_next      = addr1_reg;
        desc_next       = desc_reg;
        desc_valid_next = desc_valid_reg;
        ram_we          = 1'b0;
        ram_addr        = rd_addr;
        ram_wdata       = data;

        // Drop the block request once the pixel stage takes it
        if (desc_valid_reg && desc_ready)
        begin
            desc_valid_next = 1'b0;
        end

        // Store read data returning from the previous step
        if (cap_valid_reg)
        begin
            desc_next.vbytes[cap_idx_reg] = ram_rdata;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                // Sweep the video memory to zero
                ram_we        = 1'b1;
                ram_addr      = clr_addr_reg;
                ram_wdata     = 8'd0;
                clr_addr_next = clr_addr_reg + 15'd1;
                if (clr_addr_reg == {vgb_pkg::VRAM_AW{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (func)
                        vgb_pkg::FUNC_VRAM:
                        begin
                            ram_we    = 1'b1;
                            ram_addr  = address;
                            ram_wdata = data;
                        end
                        vgb_pkg::FUNC_PAL:
                        begin
                            desc_next.op       = vgb_pkg::OP_PAL;
                            desc_next.pal_addr = address[3:0];
                            desc_next.pal_data = data[6:0];
                            desc_valid_next    = 1'b1;
                        end
                        vgb_pkg::FUNC_TICK:
                        begin
                            desc_next.op         = vgb_pkg::OP_TICK;
                            desc_next.beam_x     = beam_x_reg;
                            desc_next.beam_y     = beam_y_reg;
                            desc_next.irq        = irq;
                            desc_next.border_idx = {border_reg[5], border_reg[2:0]};
                            // Advance the beam
                            if (bx_inc >= 11'(vgb_pkg::TOTAL_W))
                            begin
                                beam_x_next = 10'd0;
                                if (beam_y_reg == 9'(vgb_pkg::TOTAL_H - 1))
                                begin
                                    beam_y_next = 9'd0;
                                end
                                else
                                begin
                                    beam_y_next = beam_y_reg + 9'd1;
                                end
                            end
                            else
                            begin
                                beam_x_next = bx_inc[9:0];
                            end
                            if (blank)
                            begin
                                desc_next.kind  = vgb_pkg::BLK_BLANK;
                                desc_next.attr  = attr_reg;
                                desc_valid_next = 1'b1;
                            end
                            else if (in_border)
                            begin
                                desc_next.kind  = vgb_pkg::BLK_BORDER;
                                desc_next.attr  = vgb_pkg::BORDER_ATTR;
                                attr_next       = vgb_pkg::BORDER_ATTR;
                                desc_valid_next = 1'b1;
                            end
                            else
                            begin
                                rd_idx_next = 2'd0;
                                state_next  = ST_READ;
                                case (video_mode)
                                    2'd0:
                                    begin
                                        desc_next.kind = vgb_pkg::BLK_CELL;
                                        addr0_next     = m1_bits_addr;
                                        addr1_next     = m1_attr_addr;
                                        rd_last_next   = 2'd1;
                                    end
                                    2'd1:
                                    begin
                                        desc_next.kind = vgb_pkg::BLK_CELL;
                                        addr0_next     = m2_cell_addr;
                                        addr1_next     = m2_attr_addr;
                                        rd_last_next   = 2'd1;
                                    end
                                    2'd2:
                                    begin
                                        desc_next.kind = vgb_pkg::BLK_MODE3;
                                        addr0_next     = base_addr;
                                        rd_last_next   = 2'd3;
                                    end
                                    default:
                                    begin
                                        desc_next.kind = vgb_pkg::BLK_MODE4;
                                        addr0_next     = base_addr;
                                        rd_last_next   = 2'd3;
                                    end
                                endcase
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                // Issue one read a cycle
                cap_valid_next = 1'b1;
                cap_idx_next   = rd_idx_reg;
                if (rd_idx_reg == rd_last_reg)
                begin
                    state_next = ST_WAIT;
                end
                else
                begin
                    rd_idx_next = rd_idx_reg + 2'd1;
                end
            end
            ST_WAIT:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // Latch the attribute and hand the block on
                if (desc_reg.kind == vgb_pkg::BLK_CELL)
                begin
                    attr_next      = desc_reg.vbytes[1];
                    desc_next.attr = desc_reg.vbytes[1];
                end
                else
                begin
                    attr_next      = desc_reg.vbytes[3];
                    desc_next.attr = desc_reg.vbytes[3];
                end
                desc_valid_next = 1'b1;
                state_next      = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            beam_x_reg     <= '0;
            beam_y_reg     <= '0;
            attr_reg       <= '0;
            rd_idx_reg     <= '0;
            rd_last_reg    <= '0;
            cap_valid_reg  <= 1'b0;
            cap_idx_reg    <= '0;
            desc_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            beam_x_reg     <= beam_x_next;
            beam_y_reg     <= beam_y_next;
            attr_reg       <= attr_next;
            rd_idx_reg     <= rd_idx_next;
            rd_last_reg    <= rd_last_next;
            cap_valid_reg  <= cap_valid_next;
            cap_idx_reg    <= cap_idx_next;
            desc_valid_reg <= desc_valid_next;
        end
    end

    // Hold addresses and the block request payload
    always_ff @(posedge clk)
    begin
        addr0_reg <= addr0_next;
        addr1_reg <= addr1_next;
        desc_reg  <= desc_next;
    end

    assign desc_valid = desc_valid_reg;
    assign desc       = desc_reg;

endmodule

`default_nettype wire

// ----- rtl/vgb_pixel.sv -----
// Pixel stage: palette and sixteen-pixel emission of each block.
`default_nettype none

module vgb_pixel (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              desc_valid,
    output logic                                   desc_ready,
    input  wire vgb_pkg::desc_t                    desc,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [vgb_pkg::OUT_TDATA_W-1:0]        m_tdata,
    output logic                                   m_tlast
);

    logic                                 busy_reg, busy_next;
    logic [3:0]                           cnt_reg, cnt_next;
    vgb_pkg::desc_t                       cur_reg, cur_next;
    logic [6:0]                           palette_reg [16];
    logic                                 m_tvalid_reg, m_tvalid_next;
    logic [vgb_pkg::OUT_TDATA_W-1:0]      m_tdata_reg, m_tdata_next;
    logic                                 m_tlast_reg, m_tlast_next;

    logic                                 adv;
    logic                                 take;
    logic [7:0]                           sel_byte;
    logic                                 use_pal;
    logic [3:0]                           pal_idx;
    logic [6:0]                           color;
    logic [9:0]                           pixel_x;

    // Emit a pixel when the output register is free or being drained
    assign adv        = busy_reg && (!m_tvalid_reg || m_tready);
    assign desc_ready = !busy_reg || (adv && (cnt_reg == 4'd15));
    assign take       = desc_valid && desc_ready;

    // Palette index of the current pixel
    assign sel_byte = cur_reg.vbytes[cnt_reg[3:2]];
    always_comb
    begin
        use_pal = 1'b1;
        pal_idx = 4'd0;
        case (cur_reg.kind)
            vgb_pkg::BLK_BLANK:
            begin
                use_pal = 1'b0;
            end
            vgb_pkg::BLK_BORDER:
            begin
                pal_idx = cur_reg.border_idx;
            end
            vgb_pkg::BLK_CELL:
            begin
                // Ink or paper by the bitmap bit, each bit spans two pixels
                if (cur_reg.vbytes[0][3'd7 - cnt_reg[3:1]])
                begin
                    pal_idx = {cur_reg.attr[6], cur_reg.attr[2:0]};
                end
                else
                begin
                    pal_idx = {1'b0, cur_reg.attr[5:3]};
                end
            end
            vgb_pkg::BLK_MODE3:
            begin
                pal_idx = {2'b00, sel_byte[{~cnt_reg[1:0], 1'b0} +: 2]};
            end
            vgb_pkg::BLK_MODE4:
            begin
                pal_idx = cnt_reg[1] ? sel_byte[3:0] : sel_byte[7:4];
            end
            default:
            begin
                use_pal = 1'b0;
            end
        endcase
    end

    assign color   = use_pal ? palette_reg[pal_idx] : 7'd0;
    assign pixel_x = cur_reg.beam_x + {6'd0, cnt_reg};

    always_comb
    begin
        busy_next     = busy_reg;
        cnt_next      = cnt_reg;
        cur_next      = cur_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;

        // Drop a pixel once taken
        if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        // Advance through the block
        if (adv)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {5'd0, cur_reg.irq, cur_reg.attr, color, cur_reg.beam_y, pixel_x};
            m_tlast_next  = (cnt_reg == 4'd15);
            cnt_next      = cnt_reg + 4'd1;
            if (cnt_reg == 4'd15)
            begin
                busy_next = 1'b0;
            end
        end

        // Load the next block
        if (take && (desc.op == vgb_pkg::OP_TICK))
        begin
            cur_next  = desc;
            cnt_next  = 4'd0;
            busy_next = 1'b1;
        end
    end

    // Hold control state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg     <= busy_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Hold the block and the output payload
    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    // Write palette entries in request order
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                palette_reg[i] <= 7'd0;
            end
        end
        else if (take && (desc.op == vgb_pkg::OP_PAL))
        begin
            palette_reg[desc.pal_addr] <= desc.pal_data;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

// ----- rtl/four_mode_video_block_generator_core.sv -----
// Top level of the four-mode video block generator.
`default_nettype none

// After reset the block sweeps its 32 KiB video memory to zero, with s_tready
// low; then it takes requests. A block tick gives sixteen pixel results, one a
// cycle unless m_tready is low, so the pixel stage sets the sustained tick rate.
// The fetch stage works ahead of it: a border or blanked tick is handed on from
// the idle state, a screen tick takes two or four reads through the single
// video memory port, overlapped with the pixels of the tick before. Video memory
// writes are done in the fetch stage as the request is taken; palette writes
// travel in order with the ticks and are applied between blocks.

module four_mode_video_block_generator_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // address[14:0], data[22:15], video_mode[24:23], border_reg[32:25],
    // line_int[40:33], zero[47:41]
    input  wire logic [47:0] s_tdata,
    // func[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // pixel_x[9:0], pixel_y[18:10], color[25:19], attribute[33:26],
    // line_irq[34], zero[39:35]
    output logic [39:0]      m_tdata,
    output logic             m_tlast
);

    logic                           ram_we;
    logic [vgb_pkg::VRAM_AW-1:0]    ram_addr;
    logic [7:0]                     ram_wdata;
    logic [7:0]                     ram_rdata;
    logic                           desc_valid;
    logic                           desc_ready;
    vgb_pkg::desc_t                 desc;

    vgb_ram #(
        .ADDR_W (vgb_pkg::VRAM_AW),
        .DATA_W (8)
    ) u_vram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    vgb_fetch u_fetch (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .ram_we     (ram_we),
        .ram_addr   (ram_addr),
        .ram_wdata  (ram_wdata),
        .ram_rdata  (ram_rdata),
        .desc_valid (desc_valid),
        .desc_ready (desc_ready),
        .desc       (desc)
    );

    vgb_pixel u_pixel (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc_valid (desc_valid),
        .desc_ready (desc_ready),
        .desc       (desc),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire
